// File: src/btd_pkg.sv
package btd_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 8;
  localparam int unsigned LINE_W          = 8;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned THRESH_W        = 16;
  localparam int unsigned MASK_W          = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW_MASK = 2'd2;

  localparam logic [THRESH_W-1:0] DEBOUNCE_MS_RST     = 16'd20;
  localparam logic [THRESH_W-1:0] HOLD_MS_RST         = 16'd500;
  localparam logic [LINE_W-1:0]   ACTIVE_LOW_MASK_RST = 8'd0;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_USED_W  = 2 * MASK_W + 1;

  typedef struct packed {
    logic [THRESH_W-1:0] debounce_ms;
    logic [THRESH_W-1:0] hold_ms;
  } btd_thresh_t;

  typedef struct packed {
    logic tap;
    logic hold;
    logic busy;
  } btd_evt_t;

endpackage

// File: src/btd_lane.sv
module btd_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        act_i,
  input  logic [btd_pkg::TIME_W-1:0]  now_ms_i,
  input  btd_pkg::btd_thresh_t        thresh_i,
  output btd_pkg::btd_evt_t           evt_o
);
  import btd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DEB     = 3'd1,
    PH_PRESSED = 3'd2,
    PH_TAPREL  = 3'd3,
    PH_HELD    = 3'd4,
    PH_HOLDREL = 3'd5
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [TIME_W-1:0]  stamp_q, stamp_d;
  logic [TIME_W-1:0]  elapsed;
  logic               deb_done, hold_done;

  assign elapsed   = now_ms_i - stamp_q;
  assign deb_done  = elapsed >= {{(TIME_W-THRESH_W){1'b0}}, thresh_i.debounce_ms};
  assign hold_done = elapsed >= {{(TIME_W-THRESH_W){1'b0}}, thresh_i.hold_ms};

  always_comb begin
    phase_d  = phase_q;
    stamp_d  = stamp_q;
    evt_o    = '0;
    case (phase_q)
      PH_DEB: begin
        if (!act_i) begin
          phase_d = PH_IDLE;
        end else if (deb_done) begin
          phase_d = PH_PRESSED;
          stamp_d = now_ms_i;
        end
      end
      PH_PRESSED: begin
        if (!act_i) begin
          phase_d = PH_TAPREL;
          stamp_d = now_ms_i;
        end else if (hold_done) begin
          evt_o.hold = 1'b1;
          phase_d    = PH_HELD;
        end
      end
      PH_TAPREL: begin
        if (act_i) begin
          phase_d = PH_PRESSED;
          stamp_d = now_ms_i;
        end else if (deb_done) begin
          evt_o.tap = 1'b1;
          phase_d   = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (!act_i) begin
          phase_d = PH_HOLDREL;
          stamp_d = now_ms_i;
        end
      end
      PH_HOLDREL: begin
        if (act_i) begin
          phase_d = PH_HELD;
        end else if (deb_done) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        if (act_i) begin
          phase_d = PH_DEB;
          stamp_d = now_ms_i;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
    evt_o.busy = phase_d != PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      stamp_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      stamp_q <= stamp_d;
    end
  end

endmodule

// File: src/btd_merge.sv
module btd_merge #(
  parameter int unsigned NumButtons = btd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  btd_pkg::btd_evt_t                evt_i [NumButtons],
  output logic                             ready_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [btd_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
  import btd_pkg::*;

  logic [MASK_W-1:0]   tap_mask, hold_mask;
  logic                any_busy;
  logic [M_USED_W-1:0] res;

  logic                out_valid_q, skid_valid_q;
  logic [M_USED_W-1:0] out_data_q, skid_data_q;

  always_comb begin
    tap_mask  = '0;
    hold_mask = '0;
    any_busy  = 1'b0;
    for (int unsigned i = 0; i < NumButtons; i++) begin
      if (i < MASK_W) begin
        tap_mask[i[$clog2(MASK_W)-1:0]]  = evt_i[i].tap;
        hold_mask[i[$clog2(MASK_W)-1:0]] = evt_i[i].hold;
      end
      any_busy = any_busy | evt_i[i].busy;
    end
  end

  assign res     = {any_busy, hold_mask, tap_mask};
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= step_i;
      end
    end else if (step_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_data_q <= skid_valid_q ? skid_data_q : res;
    end else if (step_i) begin
      skid_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, out_data_q};

endmodule

// File: src/button_tap_hold_debouncer.sv
// Debounces up to NUM_BUTTONS button lines and reports taps and holds. Each
// input transfer carries one sample of the lines and the current millisecond
// time; each sample yields exactly one output transfer holding a tap mask, a
// hold mask and a busy flag. Every button has its own state machine lane, all
// lanes step together on the same sample, and a merge stage gathers their
// events. One sample is taken per clock cycle while s_axis_tready is high; the
// result is registered and a two-entry output buffer absorbs downstream stalls.
// Buttons above index seven never press and have no mask bits.
module button_tap_hold_debouncer #(
  parameter int unsigned NUM_BUTTONS = btd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [btd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [btd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // line_levels[7:0], now_ms[39:8]
  input  logic [btd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tap_mask[7:0], hold_mask[15:8], any_busy[16], zero fill
  output logic [btd_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import btd_pkg::*;

  btd_thresh_t       thresh_q;
  logic [LINE_W-1:0] active_low_q;

  logic              step;
  logic [LINE_W-1:0] levels;
  logic [TIME_W-1:0] now_ms;
  btd_evt_t          evt [NUM_BUTTONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.debounce_ms <= DEBOUNCE_MS_RST;
      thresh_q.hold_ms     <= HOLD_MS_RST;
      active_low_q         <= ACTIVE_LOW_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE_MS:     thresh_q.debounce_ms <= cfg_wdata_i;
        CFG_HOLD_MS:         thresh_q.hold_ms     <= cfg_wdata_i;
        CFG_ACTIVE_LOW_MASK: active_low_q         <= cfg_wdata_i[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  assign step   = s_axis_tvalid && s_axis_tready;
  assign levels = s_axis_tdata[LINE_W-1:0];
  assign now_ms = s_axis_tdata[LINE_W +: TIME_W];

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic act;
    if (g < LINE_W) begin : g_line
      assign act = levels[g] ^ active_low_q[g];
    end else begin : g_none
      assign act = 1'b0;
    end

    btd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .act_i    (act),
      .now_ms_i (now_ms),
      .thresh_i (thresh_q),
      .evt_o    (evt[g])
    );
  end

  btd_merge #(
    .NumButtons (NUM_BUTTONS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .evt_i         (evt),
    .ready_o       (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import btd_pkg::*;

  localparam int unsigned NB          = NUM_BUTTONS_DEF;
  localparam int unsigned QUIET_LIMIT = 5000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_PRESSED,
    PH_TAP_RELEASE,
    PH_HELD,
    PH_HOLD_RELEASE
  } button_phase_e;

  typedef struct packed {
    logic [MASK_W-1:0] tap;
    logic [MASK_W-1:0] hold;
    logic              busy;
  } btn_event_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  logic [THRESH_W-1:0] deb_cfg;
  logic [THRESH_W-1:0] hold_cfg;
  logic [LINE_W-1:0]   low_mask_cfg;
  button_phase_e       phase_q  [NB];
  logic [TIME_W-1:0]   stamp_ms [NB];

  btn_event_t        exp_events[$];
  btn_event_t        head_event;
  int                error_count    = 0;
  int unsigned       src_idle_pct   = 0;
  int unsigned       sink_stall_pct = 0;
  int unsigned       quiet_cycles   = 0;
  logic [LINE_W-1:0] level_state    = '0;
  logic [TIME_W-1:0] clock_ms       = '0;

  button_tap_hold_debouncer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic btn_event_t advance_buttons(input logic [LINE_W-1:0] levels,
                                                 input logic [TIME_W-1:0] now);
    btn_event_t        res;
    logic              act;
    logic [TIME_W-1:0] elapsed;
    button_phase_e     ph;
    res = '0;
    for (int b = 0; b < NB; b++) begin
      act     = levels[b] ^ low_mask_cfg[b];
      elapsed = now - stamp_ms[b];
      ph      = phase_q[b];
      case (ph)
        PH_DEBOUNCE: begin
          if (!act) begin
            ph = PH_IDLE;
          end else if (elapsed >= deb_cfg) begin
            ph = PH_PRESSED;
            stamp_ms[b] = now;
          end
        end
        PH_PRESSED: begin
          if (!act) begin
            ph = PH_TAP_RELEASE;
            stamp_ms[b] = now;
          end else if (elapsed >= hold_cfg) begin
            res.hold[b] = 1'b1;
            ph = PH_HELD;
          end
        end
        PH_TAP_RELEASE: begin
          if (act) begin
            ph = PH_PRESSED;
            stamp_ms[b] = now;
          end else if (elapsed >= deb_cfg) begin
            res.tap[b] = 1'b1;
            ph = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (!act) begin
            ph = PH_HOLD_RELEASE;
            stamp_ms[b] = now;
          end
        end
        PH_HOLD_RELEASE: begin
          if (act) begin
            ph = PH_HELD;
          end else if (elapsed >= deb_cfg) begin
            ph = PH_IDLE;
          end
        end
        default: begin
          if (act) begin
            ph = PH_DEBOUNCE;
            stamp_ms[b] = now;
          end else begin
            ph = PH_IDLE;
          end
        end
      endcase
      phase_q[b] = ph;
      if (ph != PH_IDLE) res.busy = 1'b1;
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic send_sample(input logic [LINE_W-1:0] levels, input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, levels};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_events.push_back(advance_buttons(levels, now));
  endtask

  // hold off the sender until every pending result has been transferred
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (exp_events.size() != 0);
  endtask

  task automatic apply_config(input logic [THRESH_W-1:0] deb, input logic [THRESH_W-1:0] hold,
                              input logic [LINE_W-1:0] low_mask);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DEBOUNCE_MS;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    deb_cfg      = deb;
    cfg_idx_i   <= CFG_HOLD_MS;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    hold_cfg     = hold;
    cfg_idx_i   <= CFG_ACTIVE_LOW_MASK;
    cfg_wdata_i <= CFG_DATA_W'(low_mask);
    @(posedge clk_i);
    low_mask_cfg = low_mask;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_step();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(TIME_W'(deb_cfg) + 1);
      5:             return TIME_W'(deb_cfg) + $urandom_range(2) - 1;
      6:             return TIME_W'(hold_cfg) + $urandom_range(2) - 1;
      7:             return $urandom_range(TIME_W'(hold_cfg) + 1);
      8:             return '0;
      default:       return $urandom();
    endcase
  endfunction

  task automatic random_sample();
    logic [LINE_W-1:0] flips;
    flips = '0;
    for (int b = 0; b < LINE_W; b++) begin
      if ($urandom_range(99) < 12) flips[b] = 1'b1;
    end
    level_state ^= flips;
    if ($urandom_range(49) == 0) level_state = LINE_W'($urandom());
    if ($urandom_range(99) == 0) clock_ms = $urandom();
    else clock_ms += pick_step();
    send_sample(level_state, clock_ms);
  endtask

  task automatic test_reset_defaults();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_sample(8'h00, 32'd0);
    send_sample(8'hFF, 32'd100);
    send_sample(8'hFF, 32'd119);
    send_sample(8'hFF, 32'd120);
    send_sample(8'hFF, 32'd619);
    send_sample(8'hFF, 32'd620);
    send_sample(8'hFF, 32'd650);
    send_sample(8'h00, 32'd700);
    send_sample(8'hFF, 32'd705);
    send_sample(8'h00, 32'd710);
    send_sample(8'h00, 32'd729);
    send_sample(8'h00, 32'd730);
    send_sample(8'h01, 32'd1000);
    send_sample(8'h01, 32'd1020);
    send_sample(8'h00, 32'd1030);
    send_sample(8'h01, 32'd1035);
    send_sample(8'h00, 32'd1040);
    send_sample(8'h00, 32'd1059);
    send_sample(8'h00, 32'd1060);
    send_sample(8'h02, 32'd1100);
    send_sample(8'h00, 32'd1105);
    send_sample(8'h04, 32'hFFFF_FFF0);
    send_sample(8'h04, 32'h0000_0004);
    send_sample(8'h00, 32'h0000_0010);
    send_sample(8'h00, 32'h0000_0024);
  endtask

  task automatic test_zero_thresholds();
    apply_config(16'd0, 16'd0, 8'hFF);
    send_sample(8'h00, 32'd5);
    send_sample(8'h00, 32'd5);
    send_sample(8'h00, 32'd5);
    send_sample(8'hFF, 32'd6);
    send_sample(8'hFF, 32'd6);
    send_sample(8'h0F, 32'hFFFF_FFFF);
    send_sample(8'h0F, 32'hFFFF_FFFF);
    send_sample(8'hFF, 32'hFFFF_FFFF);
    send_sample(8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mode  [4] = '{0, 62, 0, 37};
    int unsigned stall_mode [4] = '{0, 0, 62, 37};
    for (int m = 0; m < 4; m++) begin
      src_idle_pct   = idle_mode[m];
      sink_stall_pct = stall_mode[m];
      for (int c = 0; c < 5; c++) begin
        case (c)
          0:       apply_config(DEBOUNCE_MS_RST, HOLD_MS_RST, ACTIVE_LOW_MASK_RST);
          1:       apply_config(16'd0, 16'd0, 8'hFF);
          2:       apply_config(16'hFFFF, 16'hFFFF, LINE_W'($urandom()));
          3:       apply_config(16'd3, 16'd12, LINE_W'($urandom()));
          default: apply_config(THRESH_W'($urandom_range(15)), THRESH_W'($urandom_range(60)),
                                LINE_W'($urandom()));
        endcase
        repeat (75) random_sample();
      end
    end
  endtask

  task automatic test_drain_pause();
    src_idle_pct   = 37;
    sink_stall_pct = 62;
    apply_config(16'd4, 16'd30, 8'h5A);
    repeat (20) random_sample();
    settle();
    repeat (20) random_sample();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_events.size() == 0) begin
        flag_error($sformatf("result %h with no sample pending", m_axis_tdata));
      end else begin
        head_event = exp_events.pop_front();
        if (m_axis_tdata[7:0] !== head_event.tap)
          flag_error($sformatf("tap_mask got %h want %h", m_axis_tdata[7:0], head_event.tap));
        if (m_axis_tdata[15:8] !== head_event.hold)
          flag_error($sformatf("hold_mask got %h want %h", m_axis_tdata[15:8], head_event.hold));
        if (m_axis_tdata[16] !== head_event.busy)
          flag_error($sformatf("any_busy got %b want %b", m_axis_tdata[16], head_event.busy));
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    deb_cfg      = DEBOUNCE_MS_RST;
    hold_cfg     = HOLD_MS_RST;
    low_mask_cfg = ACTIVE_LOW_MASK_RST;
    for (int b = 0; b < NB; b++) begin
      phase_q[b]  = PH_IDLE;
      stamp_ms[b] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_zero_thresholds();
    test_random_traffic();
    test_drain_pause();
    settle();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/btd_pkg.sv
src/btd_lane.sv
src/btd_merge.sv
src/button_tap_hold_debouncer.sv
verif/testbench.sv
